// ----- src/eesched_pkg.sv -----
// ----------------------------------------------------------------------------
// eesched_pkg
// Shared types and constants for the earliest event scheduler: operation
// codes, field widths and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package eesched_pkg;

  localparam int OP_W   = 3;
  localparam int TYPE_W = 4;
  localparam int TIME_W = 64;

  localparam logic [TIME_W-1:0] NONE_TIME = 64'hffff_ffff_ffff_ffff;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_GET    = 3'd2,
    OP_CHECK  = 3'd3,
    OP_POP    = 3'd4,
    OP_REBASE = 3'd5
  } op_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic capture;
    logic scan_start;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_req;
    logic scan_done;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- src/eesched_dp.sv -----
// ----------------------------------------------------------------------------
// eesched_dp
// Datapath: slot time memory, slot valid bits, input and result registers,
// and the three-stage sweep (read, rebase add, minimum compare).
// ----------------------------------------------------------------------------
`default_nettype none

module eesched_dp #(
  parameter int EVENT_SLOTS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  eesched_pkg::dp_cmd_t          cmd,
  output eesched_pkg::dp_stat_t         stat,
  input  logic [eesched_pkg::OP_W-1:0]   in_op,
  input  logic [eesched_pkg::TYPE_W-1:0] in_event_type,
  input  logic [eesched_pkg::TIME_W-1:0] in_due_time,
  input  logic [eesched_pkg::TIME_W-1:0] in_now,
  input  logic [eesched_pkg::TIME_W-1:0] in_old_base,
  input  logic [eesched_pkg::TIME_W-1:0] in_new_base,
  output logic                          out_hit,
  output logic [eesched_pkg::TYPE_W-1:0] out_result_type,
  output logic [eesched_pkg::TIME_W-1:0] out_result_time,
  output logic [eesched_pkg::TIME_W-1:0] out_earliest_time
);
  import eesched_pkg::*;

  localparam int IW = $clog2(EVENT_SLOTS);
  localparam logic [IW-1:0] LAST_SLOT = IW'(EVENT_SLOTS - 1);

  op_t               op_r;
  logic [TYPE_W-1:0] idx_r;
  logic [TIME_W-1:0] due_r;
  logic [TIME_W-1:0] now_r;
  logic [TIME_W-1:0] delta_r;

  logic [EVENT_SLOTS-1:0] slot_valid_r;
  logic [TIME_W-1:0]      slot_mem [EVENT_SLOTS];
  logic [TIME_W-1:0]      rdata_r;

  logic              min_present_r, min_present_nxt;
  logic [IW-1:0]     min_idx_r, min_idx_nxt;
  logic [TIME_W-1:0] min_due_r, min_due_nxt;

  logic              scan_req_r;
  logic              issue_r;
  logic [IW-1:0]     cnt_r;
  logic              s1_v_r;
  logic [IW-1:0]     s1_idx_r;
  logic              s2_v_r;
  logic [IW-1:0]     s2_idx_r;
  logic              s2_sv_r;
  logic [TIME_W-1:0] s2_val_r;

  logic              res_hit_r;
  logic [TYPE_W-1:0] res_type_r;
  logic [TIME_W-1:0] res_time_r;
  logic              res_hit;
  logic [TYPE_W-1:0] res_type;
  logic [TIME_W-1:0] res_time;

  logic              out_hit_r;
  logic [TYPE_W-1:0] out_type_r;
  logic [TIME_W-1:0] out_time_r;
  logic [TIME_W-1:0] out_earliest_r;

  logic              in_range;
  logic [IW-1:0]     slot_a;
  logic              cur_valid;
  logic [IW-1:0]     rd_addr;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic [TIME_W-1:0] wr_data;
  logic [TIME_W-1:0] reb_val;
  logic              take;
  logic              scan_req_nxt;

  assign in_range  = {{(32-TYPE_W){1'b0}}, idx_r} < 32'(EVENT_SLOTS);
  assign slot_a    = IW'(idx_r);
  assign cur_valid = slot_valid_r[slot_a];
  assign reb_val   = rdata_r + delta_r;

  always_comb begin
    rd_addr = cnt_r;
    if (cmd.exec) begin
      rd_addr = (op_r == OP_POP) ? min_idx_r : slot_a;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = s1_idx_r;
    wr_data = reb_val;
    if (cmd.exec && op_r == OP_ADD && in_range) begin
      wr_en   = 1'b1;
      wr_addr = slot_a;
      wr_data = due_r;
    end else if (s1_v_r && op_r == OP_REBASE && slot_valid_r[s1_idx_r]) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    rdata_r <= slot_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= op_t'(in_op);
      idx_r   <= in_event_type;
      due_r   <= in_due_time;
      now_r   <= in_now;
      delta_r <= in_new_base - in_old_base;
    end
  end

  always_comb begin
    scan_req_nxt = 1'b0;
    case (op_r)
      OP_ADD:    scan_req_nxt = in_range;
      OP_REMOVE: scan_req_nxt = in_range && cur_valid;
      OP_POP:    scan_req_nxt = min_present_r;
      OP_REBASE: scan_req_nxt = 1'b1;
      default:   scan_req_nxt = 1'b0;
    endcase
  end

  // set or clear slots on exec, drop the popped slot on capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      scan_req_r   <= 1'b0;
    end else begin
      if (cmd.exec) begin
        scan_req_r <= scan_req_nxt;
        if (op_r == OP_ADD && in_range) begin
          slot_valid_r[slot_a] <= 1'b1;
        end else if (op_r == OP_REMOVE && in_range) begin
          slot_valid_r[slot_a] <= 1'b0;
        end
      end
      if (cmd.capture && op_r == OP_POP && min_present_r) begin
        slot_valid_r[min_idx_r] <= 1'b0;
      end
    end
  end

  always_comb begin
    res_hit  = 1'b0;
    res_type = '0;
    res_time = '0;
    case (op_r)
      OP_GET: begin
        res_type = idx_r;
        res_hit  = in_range && cur_valid;
        res_time = res_hit ? rdata_r : '0;
      end
      OP_CHECK: begin
        res_hit = min_present_r && (now_r >= min_due_r);
      end
      OP_POP: begin
        res_hit  = min_present_r;
        res_type = min_present_r ? TYPE_W'(min_idx_r) : '0;
        res_time = min_present_r ? rdata_r : '0;
      end
      default: begin
        res_hit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_hit_r  <= res_hit;
      res_type_r <= res_type;
      res_time_r <= res_time;
    end
  end

  // sweep: issue read, add rebase offset, compare against running minimum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r <= 1'b0;
      cnt_r   <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        issue_r <= 1'b1;
        cnt_r   <= '0;
      end else if (issue_r) begin
        if (cnt_r == LAST_SLOT) begin
          issue_r <= 1'b0;
        end
        cnt_r <= cnt_r + 1'b1;
      end
      s1_v_r <= issue_r;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r <= cnt_r;
    s2_idx_r <= s1_idx_r;
    s2_sv_r  <= slot_valid_r[s1_idx_r];
    s2_val_r <= (op_r == OP_REBASE) ? reb_val : rdata_r;
  end

  assign take = s2_v_r && s2_sv_r && (!min_present_r || s2_val_r < min_due_r);

  always_comb begin
    min_present_nxt = min_present_r;
    min_idx_nxt     = min_idx_r;
    min_due_nxt     = min_due_r;
    if (cmd.scan_start) begin
      min_present_nxt = 1'b0;
      min_idx_nxt     = '0;
      min_due_nxt     = NONE_TIME;
    end else if (take) begin
      min_present_nxt = 1'b1;
      min_idx_nxt     = s2_idx_r;
      min_due_nxt     = s2_val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_present_r <= 1'b0;
      min_idx_r     <= '0;
      min_due_r     <= NONE_TIME;
    end else begin
      min_present_r <= min_present_nxt;
      min_idx_r     <= min_idx_nxt;
      min_due_r     <= min_due_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_hit_r      <= res_hit_r;
      out_type_r     <= res_type_r;
      out_time_r     <= res_time_r;
      out_earliest_r <= min_due_r;
    end
  end

  assign stat.scan_req  = scan_req_r;
  assign stat.scan_done = s2_v_r && (s2_idx_r == LAST_SLOT);

  assign out_hit           = out_hit_r;
  assign out_result_type   = out_type_r;
  assign out_result_time   = out_time_r;
  assign out_earliest_time = out_earliest_r;

  a_min_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load && min_present_r |-> slot_valid_r[min_idx_r])
    else $error("earliest slot is not valid between items");

  a_empty_none_time: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load && !min_present_r |-> min_due_r == NONE_TIME)
    else $error("no pending event but earliest time is not all ones");

  a_scan_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_start |-> !issue_r && !s1_v_r && !s2_v_r)
    else $error("sweep started while previous sweep in flight");

  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    stat.scan_done |=> !s2_v_r)
    else $error("sweep ran past the last slot");

endmodule

`default_nettype wire

// ----- src/eesched_ctrl.sv -----
// ----------------------------------------------------------------------------
// eesched_ctrl
// Controller: sequences accept, execute, result capture, minimum sweep and
// result hand-off; owns the input ready and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module eesched_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output eesched_pkg::dp_cmd_t  cmd,
  input  eesched_pkg::dp_stat_t stat
);
  import eesched_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EXEC = 5'b00010,
    ST_READ = 5'b00100,
    ST_SCAN = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd.load       = (state_r == ST_IDLE) && in_valid;
    cmd.exec       = (state_r == ST_EXEC);
    cmd.capture    = (state_r == ST_READ);
    cmd.scan_start = (state_r == ST_READ) && stat.scan_req;
    cmd.out_load   = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = stat.scan_req ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        if (stat.scan_done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("controller state lost one-hot encoding");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_valid_r || out_ready)
    else $error("result register overwritten before it was taken");

  a_scan_leads_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN && stat.scan_done |=> state_r == ST_DONE)
    else $error("sweep finished without moving to result hand-off");

endmodule

`default_nettype wire

// ----- src/earliest_event_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// earliest_event_scheduler_top
// Fixed slot event scheduler that tracks the earliest pending due time.
//
// Input channel (in_valid/in_ready) carries one operation per item: add,
// remove, get, check due, pop earliest, rebase. Result channel
// (out_valid/out_ready) returns exactly one item per input item.
// An item runs through execute and result capture into the result register
// when the table is not changed (get, check, a no-op remove), and then on
// through a minimum sweep when it is (add, remove, pop, rebase): the slot
// time memory has one read port, so the minimum sweep reads one slot per
// cycle through a three-stage read/add/compare pipeline. Rebase updates
// times during that same sweep. One item is in work at a time, so a new
// item waits for the last one. in_ready rises again once its result is
// in the output register, so the next item is taken while a result waits.
// A stalled receiver holds the result and stalls only the following item.
// Reset clears all valid bits and sets the earliest time to all ones; slot
// times are not cleared, as the values of empty slots are never used.
// ----------------------------------------------------------------------------
`default_nettype none

module earliest_event_scheduler_top #(
  parameter int EVENT_SLOTS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [eesched_pkg::OP_W-1:0]   in_op,
  input  logic [eesched_pkg::TYPE_W-1:0] in_event_type,
  input  logic [eesched_pkg::TIME_W-1:0] in_due_time,
  input  logic [eesched_pkg::TIME_W-1:0] in_now,
  input  logic [eesched_pkg::TIME_W-1:0] in_old_base,
  input  logic [eesched_pkg::TIME_W-1:0] in_new_base,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_hit,
  output logic [eesched_pkg::TYPE_W-1:0] out_result_type,
  output logic [eesched_pkg::TIME_W-1:0] out_result_time,
  output logic [eesched_pkg::TIME_W-1:0] out_earliest_time
);
  import eesched_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  eesched_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  eesched_dp #(
    .EVENT_SLOTS(EVENT_SLOTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_op             (in_op),
    .in_event_type     (in_event_type),
    .in_due_time       (in_due_time),
    .in_now            (in_now),
    .in_old_base       (in_old_base),
    .in_new_base       (in_new_base),
    .out_hit           (out_hit),
    .out_result_type   (out_result_type),
    .out_result_time   (out_result_time),
    .out_earliest_time (out_earliest_time)
  );

endmodule

`default_nettype wire

// ----- tb/sv/earliest_event_scheduler_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// earliest_event_scheduler_top_tb
// Self-checking bench for the slot table event scheduler. A scoreboard
// class keeps its own copy of the sixteen slots and the earliest pending
// event. It predicts every result from the accepted items and compares
// the results as they leave the block. Directed corner items come first,
// then random traffic under three sender and receiver idle mixes, with one
// long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module earliest_event_scheduler_top_tb;
  import eesched_pkg::*;

  localparam int EVENT_SLOTS = 16;
  localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;
  localparam int RANDOM_ITEMS = 170;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TYPE_W-1:0] etype;
    logic [TIME_W-1:0] due;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] oldb;
    logic [TIME_W-1:0] newb;
  } sched_cmd_t;

  typedef struct packed {
    logic              hit;
    logic [TYPE_W-1:0] rtype;
    logic [TIME_W-1:0] rtime;
    logic [TIME_W-1:0] earliest;
  } sched_result_t;

  class sched_scoreboard;
    bit                slot_full [EVENT_SLOTS];
    logic [TIME_W-1:0] slot_due [EVENT_SLOTS];
    logic [TYPE_W-1:0] min_slot = '0;
    bit                min_present = 1'b0;
    logic [TIME_W-1:0] min_due = NONE_TIME;
    sched_result_t     pending_q[$];
    int                errors = 0;
    int                results = 0;
    int                hits = 0;
    int                op_count [8];

    function void find_min();
      min_present = 1'b0;
      min_slot = '0;
      min_due = NONE_TIME;
      for (int i = 0; i < EVENT_SLOTS; i++) begin
        if (slot_full[i] && (!min_present || slot_due[i] < min_due)) begin
          min_present = 1'b1;
          min_slot = TYPE_W'(i);
          min_due = slot_due[i];
        end
      end
    endfunction

    function void note_input(sched_cmd_t c);
      sched_result_t r;
      r = '0;
      case (c.op)
        OP_ADD: begin
          slot_full[c.etype] = 1'b1;
          slot_due[c.etype] = c.due;
          find_min();
        end
        OP_REMOVE: begin
          if (slot_full[c.etype]) begin
            slot_full[c.etype] = 1'b0;
            slot_due[c.etype] = '0;
            find_min();
          end
        end
        OP_GET: begin
          r.rtype = c.etype;
          if (slot_full[c.etype]) begin
            r.hit = 1'b1;
            r.rtime = slot_due[c.etype];
          end
        end
        OP_CHECK: r.hit = min_present && (c.now >= min_due);
        OP_POP: begin
          if (min_present) begin
            r.hit = 1'b1;
            r.rtype = min_slot;
            r.rtime = slot_due[min_slot];
            slot_full[min_slot] = 1'b0;
            slot_due[min_slot] = '0;
            find_min();
          end
        end
        OP_REBASE: begin
          for (int i = 0; i < EVENT_SLOTS; i++)
            if (slot_full[i]) slot_due[i] = slot_due[i] - c.oldb + c.newb;
          find_min();
        end
        default: ;
      endcase
      r.earliest = min_due;
      pending_q.push_back(r);
      op_count[c.op]++;
    endfunction

    function void check_result(sched_result_t got);
      sched_result_t want;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: result with no item pending: hit=%0d type=%0d time=%h earliest=%h",
                 $time, got.hit, got.rtype, got.rtime, got.earliest);
        return;
      end
      want = pending_q.pop_front();
      results++;
      if (want.hit) hits++;
      if (got.hit !== want.hit || got.rtype !== want.rtype ||
          got.rtime !== want.rtime || got.earliest !== want.earliest) begin
        errors++;
        $display("%0t: mismatch expected hit=%0d type=%0d time=%h earliest=%h",
                 $time, want.hit, want.rtype, want.rtime, want.earliest);
        $display("%0t:          actual   hit=%0d type=%0d time=%h earliest=%h",
                 $time, got.hit, got.rtype, got.rtime, got.earliest);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   in_op = '0;
  logic [TYPE_W-1:0] in_event_type = '0;
  logic [TIME_W-1:0] in_due_time = '0;
  logic [TIME_W-1:0] in_now = '0;
  logic [TIME_W-1:0] in_old_base = '0;
  logic [TIME_W-1:0] in_new_base = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_hit;
  logic [TYPE_W-1:0] out_result_type;
  logic [TIME_W-1:0] out_result_time;
  logic [TIME_W-1:0] out_earliest_time;

  sched_scoreboard sb = new;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request = 0;
  int hold_left = 0;

  earliest_event_scheduler_top #(.EVENT_SLOTS(EVENT_SLOTS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_op(in_op), .in_event_type(in_event_type), .in_due_time(in_due_time),
    .in_now(in_now), .in_old_base(in_old_base), .in_new_base(in_new_base),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_hit(out_hit), .out_result_type(out_result_type),
    .out_result_time(out_result_time), .out_earliest_time(out_earliest_time)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Timeout: %0d results still pending", sb.pending_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_hit, out_result_type, out_result_time, out_earliest_time});
  end

  function automatic logic [TIME_W-1:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(3))
      0: return TIME_W'($urandom_range(40));
      1: return TIME_W'($urandom_range(5000));
      2: return rnd64();
      default: return NONE_TIME - TIME_W'($urandom_range(40));
    endcase
  endfunction

  function automatic sched_cmd_t mk(logic [OP_W-1:0] op, logic [TYPE_W-1:0] etype,
                                    logic [TIME_W-1:0] due, logic [TIME_W-1:0] now,
                                    logic [TIME_W-1:0] oldb, logic [TIME_W-1:0] newb);
    sched_cmd_t c;
    c.op = op;
    c.etype = etype;
    c.due = due;
    c.now = now;
    c.oldb = oldb;
    c.newb = newb;
    return c;
  endfunction

  function automatic sched_cmd_t random_cmd();
    sched_cmd_t c;
    int r;
    c = mk(OP_UNUSED_6, TYPE_W'($urandom), pick_time(), pick_time(), rnd64(), rnd64());
    r = $urandom_range(99);
    if (r < 30) c.op = OP_ADD;
    else if (r < 42) c.op = OP_REMOVE;
    else if (r < 55) c.op = OP_GET;
    else if (r < 72) c.op = OP_CHECK;
    else if (r < 87) c.op = OP_POP;
    else if (r < 95) c.op = OP_REBASE;
    else c.op = $urandom_range(1) ? OP_UNUSED_6 : OP_UNUSED_7;
    if (c.op == OP_CHECK && $urandom_range(1))
      c.now = sb.min_due + TIME_W'($urandom_range(2)) - 64'd1;
    if (c.op == OP_REBASE && $urandom_range(1)) begin
      c.oldb = TIME_W'($urandom_range(100));
      c.newb = TIME_W'($urandom_range(100));
    end
    return c;
  endfunction

  task automatic drive_cmd(sched_cmd_t c);
    int gap;
    gap = 0;
    while (gap < 16 && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_op = c.op;
    in_event_type = c.etype;
    in_due_time = c.due;
    in_now = c.now;
    in_old_base = c.oldb;
    in_new_base = c.newb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(c);
  endtask

  initial begin
    int drain;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 26;
    recv_idle_pct = 75;
    drive_cmd(mk(OP_CHECK, 4'd0, rnd64(), 64'd0, rnd64(), rnd64()));
    drive_cmd(mk(OP_POP, 4'd9, rnd64(), NONE_TIME, rnd64(), rnd64()));
    drive_cmd(mk(OP_GET, 4'd5, rnd64(), rnd64(), rnd64(), rnd64()));
    drive_cmd(mk(OP_REMOVE, 4'd3, rnd64(), rnd64(), rnd64(), rnd64()));
    drive_cmd(mk(OP_ADD, 4'd0, NONE_TIME, rnd64(), rnd64(), rnd64()));
    drive_cmd(mk(OP_CHECK, 4'd0, rnd64(), NONE_TIME - 64'd1, rnd64(), rnd64()));
    drive_cmd(mk(OP_ADD, 4'd15, 64'd0, rnd64(), rnd64(), rnd64()));
    drive_cmd(mk(OP_ADD, 4'd7, 64'd0, rnd64(), rnd64(), rnd64()));
    drive_cmd(mk(OP_GET, 4'd15, rnd64(), rnd64(), rnd64(), rnd64()));
    drive_cmd(mk(OP_CHECK, 4'd0, rnd64(), 64'd0, rnd64(), rnd64()));
    drive_cmd(mk(OP_ADD, 4'd7, 64'd100, rnd64(), rnd64(), rnd64()));
    drive_cmd(mk(OP_POP, 4'd0, rnd64(), 64'd0, rnd64(), rnd64()));
    drive_cmd(mk(OP_CHECK, 4'd0, rnd64(), 64'd99, rnd64(), rnd64()));
    drive_cmd(mk(OP_REBASE, 4'd0, rnd64(), rnd64(), 64'd200, 64'd50));
    drive_cmd(mk(OP_REBASE, 4'd0, rnd64(), rnd64(), NONE_TIME, NONE_TIME));
    drive_cmd(mk(OP_REBASE, 4'd0, rnd64(), rnd64(), 64'd0, NONE_TIME));
    drive_cmd(mk(OP_UNUSED_6, 4'd15, rnd64(), rnd64(), rnd64(), rnd64()));
    drive_cmd(mk(OP_UNUSED_7, 4'd1, rnd64(), rnd64(), rnd64(), rnd64()));
    drive_cmd(mk(OP_ADD, 4'd3, 64'd5, rnd64(), rnd64(), rnd64()));
    drive_cmd(mk(OP_REMOVE, 4'd3, rnd64(), rnd64(), rnd64(), rnd64()));
    drive_cmd(mk(OP_POP, 4'd0, rnd64(), rnd64(), rnd64(), rnd64()));
    drive_cmd(mk(OP_POP, 4'd0, rnd64(), rnd64(), rnd64(), rnd64()));
    drive_cmd(mk(OP_POP, 4'd0, rnd64(), rnd64(), rnd64(), rnd64()));
    drive_cmd(mk(OP_CHECK, 4'd0, rnd64(), NONE_TIME, rnd64(), rnd64()));

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 26 : (mode == 1) ? 75 : 0;
      recv_idle_pct = (mode == 0) ? 75 : (mode == 1) ? 26 : 0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
        drive_cmd(random_cmd());
        if (mode == 2 && i == 60) hold_request = 300;
      end
    end
    @(negedge clk);
    in_valid = 1'b0;

    drain = 0;
    while (sb.pending_q.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (3 * EVENT_SLOTS) @(posedge clk);
    if (sb.pending_q.size() != 0) begin
      sb.errors += sb.pending_q.size();
      $display("%0t: %0d results never arrived", $time, sb.pending_q.size());
    end

    $display("Covered %0d results, %0d with hit: add %0d, remove %0d, get %0d, check %0d,",
             sb.results, sb.hits, sb.op_count[OP_ADD], sb.op_count[OP_REMOVE],
             sb.op_count[OP_GET], sb.op_count[OP_CHECK]);
    $display("pop %0d, rebase %0d, unused %0d; three idle mixes and a long output hold-off",
             sb.op_count[OP_POP], sb.op_count[OP_REBASE],
             sb.op_count[OP_UNUSED_6] + sb.op_count[OP_UNUSED_7]);
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
